/* rtl/char_lcd_text_cursor_writer_core_macros.svh */
// ----------------------------------------------------------------------------
// char_lcd_text_cursor_writer_core_macros
// assertion macros used by the back end (cltw_back) of the lcd text writer
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_TEXT_CURSOR_WRITER_CORE_MACROS_SVH
`define CHAR_LCD_TEXT_CURSOR_WRITER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CLTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CLTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/cltw_pkg.sv */
// ----------------------------------------------------------------------------
// cltw_pkg
// types, codes and the row base table of the lcd text writer
// ----------------------------------------------------------------------------
package cltw_pkg;

	localparam int WIDTH_W  = 6;
	localparam int COUNT_W  = 3;
	localparam int COL_W    = 8;
	localparam int ROW_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int QUEUE_DEPTH_DEF = 4;

	// request codes
	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_GOTO  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT = 1'd1;

	localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = 6'd16;
	localparam logic [COUNT_W-1:0] LINE_COUNT_RST = 3'd2;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CMD_CLEAR = 8'h01;

	localparam logic RS_CMD  = 1'b0;
	localparam logic RS_DATA = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [7:0]         char_code;
		logic [WIDTH_W-1:0] goto_col;
		logic [ROW_W-1:0]   goto_row;
	} req_t;

	typedef struct packed {
		logic       reg_select;
		logic [3:0] bus_nibble;
		logic       last;
	} result_t;

	// one or two bus bytes decided by the front end
	typedef struct packed {
		logic       two;
		logic       rs0;
		logic [7:0] b0;
		logic       rs1;
		logic [7:0] b1;
	} entry_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		case (row)
			2'd0: base = 8'h80;
			2'd1: base = 8'hC0;
			2'd2: base = 8'h94;
			default: base = 8'hD4;
		endcase
		return base;
	endfunction

endpackage

/* rtl/char_lcd_text_cursor_writer_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_cursor_writer_core
// text front end for a 4-bit character lcd bus
// ----------------------------------------------------------------------------
// requests enter on push/full as one item: put character, go to column and
// row, or clear and home. a beat is taken when push is high and full low.
// results leave on empty/pop: each beat is one bus write, a register-select
// bit and a nibble, high nibble of a byte first, last set on the final beat
// of a request. a request gives zero, two or four beats.
// the configuration channel (cfg_valid/cfg_ready, always ready) sets
// line width and line count; write it only while the block is idle.
// the first beat of a request passes the entry queue and then the output
// register before it shows on the result ports and can be popped.
// the back end moves one beat per cycle out of the output register while
// the receiver keeps popping; the front takes one request per cycle until
// the entry queue (QUEUE_DEPTH requests) fills.
// reset clears cursor to row 0 column 0, width 16, count 2, queue empty.
// when the receiver stalls, the output register holds its beat, the queue
// fills and then full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module char_lcd_text_cursor_writer_core import cltw_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request side
	input  logic                 push,
	output logic                 full,
	input  req_t                 item,
	// result side
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDTH_W-1:0]   cfg_data
);

	// queue between the request decoder and the nibble serializer
	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;
	entry_t q_wr_entry;
	entry_t q_head;

	// front: cursor tracking, line wrap, go-to checks, byte decisions
	cltw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (q_wr_entry)
	);

	// requests that make no bus write never enter the queue
	cltw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_entry),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.q_empty (q_empty)
	);

	// back: one nibble beat per cycle into the output register unless stalled
	cltw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

/* rtl/cltw_front.sv */
// ----------------------------------------------------------------------------
// cltw_front
// takes requests, keeps the cursor and line setup, decides the bus bytes
// ----------------------------------------------------------------------------
module cltw_front import cltw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  req_t                 item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDTH_W-1:0]   cfg_data,
	input  logic                 q_full,
	output logic                 q_push,
	output entry_t               q_entry
);

	logic [WIDTH_W-1:0] width_q;
	logic [COUNT_W-1:0] count_q;
	logic [COL_W-1:0]   col_q, col_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic               accept;
	logic               emit;
	logic               lm_ok, lm_emit;
	logic [ROW_W-1:0]   nrow;
	entry_t             ent;

	assign full      = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;
	assign q_push    = accept && emit;
	assign q_entry   = ent;

	always_comb begin
		col_d   = col_q;
		row_d   = row_q;
		ent     = '0;
		emit    = 1'b0;
		lm_ok   = row_q < count_q;
		nrow    = row_q + 3'd1;
		lm_emit = lm_ok && (width_q != '0) && (nrow < count_q) && !nrow[2];
		case (item.req_type)
			REQ_PUT: begin
				if (item.char_code == CH_CR) begin
					emit = 1'b0;
				end else if (item.char_code == CH_LF) begin
					if (lm_ok) begin
						col_d = '0;
						row_d = nrow;
						if (lm_emit) begin
							emit    = 1'b1;
							ent.rs0 = RS_CMD;
							ent.b0  = row_base(nrow[1:0]);
						end
					end
				end else begin
					emit = 1'b1;
					if ((col_q >= {2'b00, width_q}) && lm_ok) begin
						// wrap to next line, the char then lands in column 0
						row_d = nrow;
						col_d = 8'd1;
						if (lm_emit) begin
							ent.two = 1'b1;
							ent.rs0 = RS_CMD;
							ent.b0  = row_base(nrow[1:0]);
							ent.rs1 = RS_DATA;
							ent.b1  = item.char_code;
						end else begin
							ent.rs0 = RS_DATA;
							ent.b0  = item.char_code;
						end
					end else begin
						col_d   = (col_q != 8'hFF) ? col_q + 8'd1 : col_q;
						ent.rs0 = RS_DATA;
						ent.b0  = item.char_code;
					end
				end
			end
			REQ_GOTO: begin
				if ((item.goto_col < width_q) && (item.goto_row < count_q)
					&& !item.goto_row[2]) begin
					emit    = 1'b1;
					ent.rs0 = RS_CMD;
					ent.b0  = row_base(item.goto_row[1:0]) + {2'b00, item.goto_col};
					col_d   = {2'b00, item.goto_col};
					row_d   = item.goto_row;
				end
			end
			REQ_CLEAR: begin
				emit    = 1'b1;
				ent.rs0 = RS_CMD;
				ent.b0  = CMD_CLEAR;
				if ((width_q != '0) && (count_q != '0)) begin
					ent.two = 1'b1;
					ent.rs1 = RS_CMD;
					ent.b1  = row_base(2'd0);
					col_d   = '0;
					row_d   = '0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= LINE_WIDTH_RST;
			count_q <= LINE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LINE_WIDTH: width_q <= cfg_data;
				CFG_LINE_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default: width_q <= width_q;
			endcase
		end
	end

endmodule

/* rtl/cltw_queue.sv */
// ----------------------------------------------------------------------------
// cltw_queue
// short first-in first-out queue of byte entries between front and back
// ----------------------------------------------------------------------------
module cltw_queue import cltw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_data,
	output logic   q_full,
	input  logic   rd_en,
	output entry_t rd_data,
	output logic   q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign q_full  = cnt_q == CNT_W'(DEPTH);
	assign q_empty = cnt_q == '0;
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/cltw_back.sv */
// ----------------------------------------------------------------------------
// cltw_back
// splits queued bytes into nibbles, high nibble first, one per unstalled cycle
// ----------------------------------------------------------------------------
module cltw_back import cltw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  entry_t  q_head,
	input  logic    q_empty,
	output logic    q_pop,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

`include "char_lcd_text_cursor_writer_core_macros.svh"

	logic [1:0] idx_q;
	logic       out_valid_q;
	result_t    out_q;
	logic       load;
	logic       nib_last;
	logic [7:0] cur_byte;
	logic       cur_rs;

	assign load     = !out_valid_q || pop;
	assign cur_byte = idx_q[1] ? q_head.b1 : q_head.b0;
	assign cur_rs   = idx_q[1] ? q_head.rs1 : q_head.rs0;
	assign nib_last = idx_q[0] && (idx_q[1] || !q_head.two);
	assign q_pop    = load && !q_empty && nib_last;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			out_q.reg_select <= cur_rs;
			out_q.bus_nibble <= idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
			out_q.last       <= nib_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				idx_q <= nib_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	`CLTW_ASSERT_NOW(a_idx_has_entry, idx_q != 2'd0, !q_empty, "nibble index set with no entry")
	`CLTW_ASSERT_NOW(a_single_byte, !q_empty && !q_head.two, !idx_q[1], "second byte on one-byte entry")
	`CLTW_ASSERT_NEXT(a_idx_restart, q_pop, idx_q == 2'd0, "index not cleared after entry")

endmodule
